// File: design/sfr_pkg.sv
package sfr_pkg;

  localparam int NUM_SENSORS_DEFAULT   = 5;
  localparam int HISTORY_DEPTH_DEFAULT = 10;
  localparam int FRAME_LENGTH          = 15;
  localparam int QUEUE_DEPTH           = 2;

  localparam int BYTE_W   = 8;
  localparam int ID_W     = 12;
  localparam int VALUE_W  = 19;
  localparam int PERIOD_W = 12;
  localparam int SENSOR_W = 3;
  localparam int SLOT_W   = 4;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 4;
  localparam int SUM_W    = 12;

  localparam logic [BYTE_W-1:0] START_BYTE = 8'hFD;

  // byte positions within a frame
  localparam logic [INDEX_W-1:0] POS_CHECK     = 4'd4;
  localparam logic [INDEX_W-1:0] POS_ID_TENS   = 4'd5;
  localparam logic [INDEX_W-1:0] POS_ID_ONES   = 4'd6;
  localparam logic [INDEX_W-1:0] POS_VAL_THOU  = 4'd7;
  localparam logic [INDEX_W-1:0] POS_VAL_HUND  = 4'd8;
  localparam logic [INDEX_W-1:0] POS_VAL_TENS  = 4'd9;
  localparam logic [INDEX_W-1:0] POS_VAL_ONES  = 4'd10;
  localparam logic [INDEX_W-1:0] POS_PER_TENS  = 4'd11;
  localparam logic [INDEX_W-1:0] POS_PER_ONES  = 4'd12;
  localparam logic [INDEX_W-1:0] POS_SUM_LAST  = 4'd13;
  localparam logic [INDEX_W-1:0] POS_LAST      = INDEX_W'(FRAME_LENGTH - 1);

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_ID  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_FRAME = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    status_e               status;
    logic                  in_range;
    logic                  slot_ok;
    logic [ID_W-1:0]       sensor;
    logic [VALUE_W-1:0]    value;
    logic [PERIOD_W-1:0]   period;
    logic [SLOT_W-1:0]     slot;
  } item_t;

  typedef struct packed {
    logic                  done;
    status_e               status;
    logic [ID_W-1:0]       sensor_id;
    logic [VALUE_W-1:0]    value;
    logic [PERIOD_W-1:0]   period;
    logic [VALUE_W-1:0]    history_value;
    logic [COUNT_W-1:0]    history_count;
    logic [SLOT_W-1:0]     newest_slot;
  } result_t;

endpackage

// File: design/sfr_ram.sv
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sfr_front.sv
module sfr_front #(
  parameter int NUM_SENSORS   = sfr_pkg::NUM_SENSORS_DEFAULT,
  parameter int HISTORY_DEPTH = sfr_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte_i,
  input  logic [sfr_pkg::SENSOR_W-1:0]  read_sensor_i,
  input  logic [sfr_pkg::SLOT_W-1:0]    read_slot_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output sfr_pkg::item_t                item_o
);

  logic                           accept;
  logic [sfr_pkg::INDEX_W-1:0]    idx_q, idx_d;
  logic [sfr_pkg::BYTE_W-1:0]     check_q, check_d;
  logic [sfr_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [sfr_pkg::ID_W-1:0]       id_q, id_d;
  logic [sfr_pkg::VALUE_W-1:0]    val_q, val_d;
  logic [sfr_pkg::PERIOD_W-1:0]   per_q, per_d;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign push_o     = accept;

  always_comb begin
    idx_d   = idx_q;
    check_d = check_q;
    sum_d   = sum_q;
    id_d    = id_q;
    val_d   = val_q;
    per_d   = per_q;
    item_o  = '0;
    item_o.kind = sfr_pkg::KIND_NONE;
    if (accept) begin
      if (sfr_pkg::opcode_e'(opcode_i) == sfr_pkg::OP_READ) begin
        item_o.kind     = sfr_pkg::KIND_READ;
        item_o.sensor   = sfr_pkg::ID_W'(read_sensor_i);
        item_o.in_range = int'(read_sensor_i) < NUM_SENSORS;
        item_o.slot_ok  = int'(read_slot_i) < HISTORY_DEPTH;
        item_o.slot     = read_slot_i;
      end else if (idx_q == '0) begin
        if (rx_byte_i == sfr_pkg::START_BYTE) begin
          idx_d = sfr_pkg::INDEX_W'(1);
        end
      end else begin
        // decode on the fly, no frame buffer
        case (idx_q)
          sfr_pkg::POS_CHECK:    check_d = rx_byte_i;
          sfr_pkg::POS_ID_TENS: begin
            sum_d = sfr_pkg::SUM_W'(rx_byte_i);
            id_d  = sfr_pkg::ID_W'(rx_byte_i) * sfr_pkg::ID_W'(10);
          end
          sfr_pkg::POS_ID_ONES:  id_d = id_q + sfr_pkg::ID_W'(rx_byte_i);
          sfr_pkg::POS_VAL_THOU:
            val_d = sfr_pkg::VALUE_W'(rx_byte_i) * sfr_pkg::VALUE_W'(1000);
          sfr_pkg::POS_VAL_HUND:
            val_d = val_q + sfr_pkg::VALUE_W'(rx_byte_i) * sfr_pkg::VALUE_W'(100);
          sfr_pkg::POS_VAL_TENS:
            val_d = val_q + sfr_pkg::VALUE_W'(rx_byte_i) * sfr_pkg::VALUE_W'(10);
          sfr_pkg::POS_VAL_ONES: val_d = val_q + sfr_pkg::VALUE_W'(rx_byte_i);
          sfr_pkg::POS_PER_TENS:
            per_d = sfr_pkg::PERIOD_W'(rx_byte_i) * sfr_pkg::PERIOD_W'(10);
          sfr_pkg::POS_PER_ONES: per_d = per_q + sfr_pkg::PERIOD_W'(rx_byte_i);
          default: ;
        endcase
        if (idx_q inside {[sfr_pkg::POS_ID_ONES:sfr_pkg::POS_SUM_LAST]}) begin
          sum_d = sum_q + sfr_pkg::SUM_W'(rx_byte_i);
        end
        if (idx_q == sfr_pkg::POS_LAST) begin
          idx_d           = '0;
          item_o.kind     = sfr_pkg::KIND_FRAME;
          item_o.sensor   = id_q;
          item_o.value    = val_q;
          item_o.period   = per_q;
          item_o.in_range = int'(id_q) < NUM_SENSORS;
          if (sum_q != sfr_pkg::SUM_W'(check_q)) begin
            item_o.status = sfr_pkg::ST_BAD_SUM;
          end else if (int'(id_q) >= NUM_SENSORS) begin
            item_o.status = sfr_pkg::ST_BAD_ID;
          end else begin
            item_o.status = sfr_pkg::ST_STORED;
          end
        end else begin
          idx_d = idx_q + sfr_pkg::INDEX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    check_q <= check_d;
    sum_q   <= sum_d;
    id_q    <= id_d;
    val_q   <= val_d;
    per_q   <= per_d;
  end

endmodule

// File: design/sfr_queue.sv
module sfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sfr_pkg::item_t  item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output sfr_pkg::item_t  head_o
);

  localparam int PtrW = $clog2(sfr_pkg::QUEUE_DEPTH);
  localparam int CntW = $clog2(sfr_pkg::QUEUE_DEPTH + 1);

  sfr_pkg::item_t    entries_q [sfr_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(sfr_pkg::QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: design/sfr_back.sv
module sfr_back #(
  parameter int NUM_SENSORS   = sfr_pkg::NUM_SENSORS_DEFAULT,
  parameter int HISTORY_DEPTH = sfr_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  sfr_pkg::item_t   head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sfr_pkg::result_t res_o
);

  localparam int SensAw      = NUM_SENSORS > 1 ? $clog2(NUM_SENSORS) : 1;
  localparam int HistEntries = NUM_SENSORS * HISTORY_DEPTH;
  localparam int HistAw      = $clog2(HistEntries);
  localparam int SlotW       = $clog2(HISTORY_DEPTH);
  localparam int CntW        = $clog2(HISTORY_DEPTH + 1);

  typedef struct packed {
    logic [sfr_pkg::PERIOD_W-1:0] period;
    logic [CntW-1:0]              fill;
    logic [SlotW-1:0]             wpos;
  } sens_state_t;

  localparam int StateW = $bits(sens_state_t);

  logic                          pop, b1_fire, do_write, hv_ok;
  logic                          b1_vld_q, out_vld_q;
  sfr_pkg::item_t                b1_q;
  sfr_pkg::result_t              out_q, res;
  logic [NUM_SENSORS-1:0]        sens_vld_q;
  logic [SensAw-1:0]             head_idx, b1_idx;
  logic [HistAw-1:0]             head_haddr, wr_haddr;
  logic [StateW-1:0]             st_rdata;
  logic [sfr_pkg::VALUE_W-1:0]   hv_rdata, hv_raw;
  sens_state_t                   st_raw, st_cur, st_new;
  logic                          fwd_st_q, fwd_hv_q;
  sens_state_t                   fwd_st_data_q;
  logic [sfr_pkg::VALUE_W-1:0]   fwd_hv_data_q;

  assign b1_fire = b1_vld_q && (!out_vld_q || !out_stall_i);
  assign pop     = !q_empty_i && (!b1_vld_q || b1_fire);
  assign pop_o   = pop;

  assign head_idx   = head_i.in_range ? SensAw'(head_i.sensor) : '0;
  assign head_haddr = (head_i.in_range && head_i.slot_ok)
                    ? HistAw'(head_idx) * HistAw'(HISTORY_DEPTH) + HistAw'(head_i.slot)
                    : '0;

  assign b1_idx = b1_q.in_range ? SensAw'(b1_q.sensor) : '0;

  always_comb begin
    st_raw = fwd_st_q ? fwd_st_data_q : sens_state_t'(st_rdata);
    st_cur = (b1_q.in_range && sens_vld_q[b1_idx]) ? st_raw : '0;
    do_write = (b1_q.kind == sfr_pkg::KIND_FRAME) && (b1_q.status == sfr_pkg::ST_STORED);

    st_new.period = b1_q.period;
    st_new.wpos   = (int'(st_cur.wpos) == HISTORY_DEPTH - 1) ? '0
                  : st_cur.wpos + SlotW'(1);
    st_new.fill   = (int'(st_cur.fill) < HISTORY_DEPTH) ? st_cur.fill + CntW'(1)
                  : st_cur.fill;
    wr_haddr = HistAw'(b1_idx) * HistAw'(HISTORY_DEPTH) + HistAw'(st_cur.wpos);

    // entries past the fill count were never written
    hv_raw = fwd_hv_q ? fwd_hv_data_q : hv_rdata;
    hv_ok  = (b1_q.kind == sfr_pkg::KIND_READ) && b1_q.in_range && b1_q.slot_ok
           && (int'(b1_q.slot) < int'(st_cur.fill));

    res        = '0;
    res.status = sfr_pkg::ST_STORED;
    case (b1_q.kind)
      sfr_pkg::KIND_FRAME: begin
        res.done      = 1'b1;
        res.status    = b1_q.status;
        res.sensor_id = b1_q.sensor;
        res.value     = b1_q.value;
        res.period    = b1_q.period;
        if (do_write) begin
          res.history_count = sfr_pkg::COUNT_W'(st_new.fill);
          res.newest_slot   = sfr_pkg::SLOT_W'(st_new.wpos);
        end else begin
          res.history_count = sfr_pkg::COUNT_W'(st_cur.fill);
          res.newest_slot   = sfr_pkg::SLOT_W'(st_cur.wpos);
        end
      end
      sfr_pkg::KIND_READ: begin
        res.sensor_id     = b1_q.sensor;
        res.period        = st_cur.period;
        res.history_value = hv_ok ? hv_raw : '0;
        res.history_count = sfr_pkg::COUNT_W'(st_cur.fill);
        res.newest_slot   = sfr_pkg::SLOT_W'(st_cur.wpos);
      end
      default: ;
    endcase
  end

  sfr_ram #(
    .WIDTH (StateW),
    .DEPTH (NUM_SENSORS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (b1_fire && do_write),
    .waddr_i (b1_idx),
    .wdata_i (st_new),
    .re_i    (pop),
    .raddr_i (head_idx),
    .rdata_o (st_rdata)
  );

  sfr_ram #(
    .WIDTH (sfr_pkg::VALUE_W),
    .DEPTH (HistEntries)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (b1_fire && do_write),
    .waddr_i (wr_haddr),
    .wdata_i (b1_q.value),
    .re_i    (pop),
    .raddr_i (head_haddr),
    .rdata_o (hv_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      sens_vld_q <= '0;
      fwd_st_q   <= 1'b0;
      fwd_hv_q   <= 1'b0;
    end else begin
      if (pop) begin
        b1_vld_q <= 1'b1;
      end else if (b1_fire) begin
        b1_vld_q <= 1'b0;
      end
      if (b1_fire) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
      if (b1_fire && do_write) begin
        sens_vld_q[b1_idx] <= 1'b1;
      end
      // bypass a write that lands on the same edge as the read
      if (pop) begin
        fwd_st_q <= b1_fire && do_write && (head_idx == b1_idx);
        fwd_hv_q <= b1_fire && do_write && (head_haddr == wr_haddr);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b1_q          <= head_i;
      fwd_st_data_q <= st_new;
      fwd_hv_data_q <= b1_q.value;
    end
    if (b1_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign res_o       = out_q;

endmodule

// File: design/sensor_frame_receiver.sv
// Path: an accepted word passes the queue, the lookup stage and the output register.
// Throughput: one word per cycle when unstalled; the history and per-sensor state RAMs
// take one read and one write per cycle, with a bypass for back-to-back access.
// Reset: asynchronous, active low; clears hunt state, queue, pipeline and per-sensor
// valid bits. The history RAM is not swept: unwritten entries are masked by fill count.
module sensor_frame_receiver #(
  parameter int NUM_SENSORS   = sfr_pkg::NUM_SENSORS_DEFAULT,
  parameter int HISTORY_DEPTH = sfr_pkg::HISTORY_DEPTH_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [sfr_pkg::BYTE_W-1:0]     rx_byte_i,
  input  logic [sfr_pkg::SENSOR_W-1:0]   read_sensor_i,
  input  logic [sfr_pkg::SLOT_W-1:0]     read_slot_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           frame_done_o,
  output logic [sfr_pkg::STATUS_W-1:0]   frame_status_o,
  output logic [sfr_pkg::ID_W-1:0]       sensor_id_o,
  output logic [sfr_pkg::VALUE_W-1:0]    value_hundredths_o,
  output logic [sfr_pkg::PERIOD_W-1:0]   period_o,
  output logic [sfr_pkg::VALUE_W-1:0]    history_value_o,
  output logic [sfr_pkg::COUNT_W-1:0]    history_count_o,
  output logic [sfr_pkg::SLOT_W-1:0]     newest_slot_o
);

  logic             push, pop, q_full, q_empty;
  sfr_pkg::item_t   item, head;
  sfr_pkg::result_t res;

  sfr_front #(
    .NUM_SENSORS   (NUM_SENSORS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .rx_byte_i     (rx_byte_i),
    .read_sensor_i (read_sensor_i),
    .read_slot_i   (read_slot_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .item_o        (item)
  );

  sfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head)
  );

  sfr_back #(
    .NUM_SENSORS   (NUM_SENSORS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign frame_done_o       = res.done;
  assign frame_status_o     = res.status;
  assign sensor_id_o        = res.sensor_id;
  assign value_hundredths_o = res.value;
  assign period_o           = res.period;
  assign history_value_o    = res.history_value;
  assign history_count_o    = res.history_count;
  assign newest_slot_o      = res.newest_slot;

endmodule
